>>> rtl/core/grfc_pkg.sv
// grfc_pkg: shared types, widths, reset values and codes of the gaussian row filter
// no dependencies; compile first
`default_nettype none

package grfc_pkg;

  // fixed field widths
  localparam int PIXEL_W        = 8;
  localparam int COL_W          = 12;
  localparam int ROW_WIDTH_W    = 13;
  localparam int RADIUS_W       = 2;
  localparam int WEIGHT_W       = 16;
  localparam int TAP_W          = 3;
  localparam int WEIGHTS_LOW_W  = 64;
  localparam int WEIGHTS_HIGH_W = 48;
  localparam int ACC_W          = 27;
  localparam int FRAC_BITS      = 15;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 64;

  // default sizing of the top level
  localparam int DEF_MAX_RADIUS    = 3;
  localparam int DEF_MAX_ROW_WIDTH = 4096;

  // register reset values
  localparam logic [ROW_WIDTH_W-1:0]    ROW_WIDTH_RST    = 13'd640;
  localparam logic [RADIUS_W-1:0]       RADIUS_RST       = 2'd1;
  localparam logic [WEIGHTS_LOW_W-1:0]  WEIGHTS_LOW_RST  = 64'h0000_2000_4000_2000;
  localparam logic [WEIGHTS_HIGH_W-1:0] WEIGHTS_HIGH_RST = 48'h0;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_WIDTH,
    REG_RADIUS,
    REG_WEIGHTS_LOW,
    REG_WEIGHTS_HIGH
  } cfg_reg_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } grfc_state_t;

  // register file contents
  typedef struct packed {
    logic [ROW_WIDTH_W-1:0]    row_width;
    logic [RADIUS_W-1:0]       radius;
    logic [WEIGHTS_LOW_W-1:0]  weights_low;
    logic [WEIGHTS_HIGH_W-1:0] weights_high;
  } cfg_regs_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // take the input word, shift window, set up the column run
    logic mac;   // accumulate one tap
    logic emit;  // move the finished sum into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic produce;   // the word at the input causes results
    logic tap_last;  // current tap is the last one of the kernel
    logic col_last;  // current column is the last one of the run
    logic out_free;  // output register can take a word this cycle
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/grfc_pixel_if.sv
// grfc_pixel_if: input pixel channel, valid/ready with one pixel per word
// depends on grfc_pkg
`default_nettype none

interface grfc_pixel_if;
  import grfc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/grfc_result_if.sv
// grfc_result_if: filtered pixel channel, valid/ready with column and row tags
// depends on grfc_pkg
`default_nettype none

interface grfc_result_if;
  import grfc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_out;
  logic [COL_W-1:0]   out_column;
  logic               row_end;
  logic               run_last;

  modport source (output valid, output pixel_out, output out_column, output row_end,
                  output run_last, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input row_end,
                  input run_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/grfc_cfg_if.sv
// grfc_cfg_if: configuration write channel, valid/ready with register index and data
// depends on grfc_pkg
`default_nettype none

interface grfc_cfg_if;
  import grfc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/grfc_cfg_regs.sv
// grfc_cfg_regs: configuration register file written through the config channel
// depends on grfc_pkg
`default_nettype none

module grfc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_valid,
  output logic                            wr_ready,
  input  logic [grfc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [grfc_pkg::CFG_DATA_W-1:0]  wr_data,
  output grfc_pkg::cfg_regs_t             regs
);
  import grfc_pkg::*;

  cfg_reg_t sel;

  assign wr_ready = 1'b1;
  assign sel      = cfg_reg_t'(wr_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.row_width    <= ROW_WIDTH_RST;
      regs.radius       <= RADIUS_RST;
      regs.weights_low  <= WEIGHTS_LOW_RST;
      regs.weights_high <= WEIGHTS_HIGH_RST;
    end else if (wr_valid) begin
      unique case (sel)
        REG_ROW_WIDTH:    regs.row_width    <= wr_data[ROW_WIDTH_W-1:0];
        REG_RADIUS:       regs.radius       <= wr_data[RADIUS_W-1:0];
        REG_WEIGHTS_LOW:  regs.weights_low  <= wr_data[WEIGHTS_LOW_W-1:0];
        REG_WEIGHTS_HIGH: regs.weights_high <= wr_data[WEIGHTS_HIGH_W-1:0];
        default:          regs.radius       <= regs.radius;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/grfc_ctrl.sv
// grfc_ctrl: sequencing state machine (accept, tap accumulation, result hand-off)
// depends on grfc_pkg
`default_nettype none

module grfc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  grfc_pkg::dp_status_t   status,
  output grfc_pkg::dp_cmd_t      cmd
);
  import grfc_pkg::*;

  grfc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.produce) begin
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if (status.tap_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for room in the output register
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.col_last ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/grfc_datapath.sv
// grfc_datapath: pixel window, column tracking, shared multiply-accumulate, output register
// depends on grfc_pkg
`default_nettype none

module grfc_datapath #(
  parameter int MAX_RADIUS    = grfc_pkg::DEF_MAX_RADIUS,
  parameter int MAX_ROW_WIDTH = grfc_pkg::DEF_MAX_ROW_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  grfc_pkg::cfg_regs_t           cfg,
  input  grfc_pkg::dp_cmd_t             cmd,
  output grfc_pkg::dp_status_t          status,
  input  logic [grfc_pkg::PIXEL_W-1:0]  pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [grfc_pkg::PIXEL_W-1:0]  pixel_out,
  output logic [grfc_pkg::COL_W-1:0]    out_column,
  output logic                          row_end,
  output logic                          run_last
);
  import grfc_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int CNT_W     = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int CMP_W     = ((CNT_W > ROW_WIDTH_W) ? CNT_W : ROW_WIDTH_W) + 1;
  localparam int PROD_W    = PIXEL_W + WEIGHT_W;

  // window, newest pixel at entry zero
  logic [PIXEL_W-1:0] window [WIN_DEPTH];

  logic [CNT_W-1:0]    column_count;
  logic [CNT_W-1:0]    newest_col;
  logic                last_q;
  logic [RADIUS_W-1:0] r_q;
  logic [RADIUS_W-1:0] k;       // distance of the output column behind the newest
  logic [RADIUS_W-1:0] k_end;
  logic [TAP_W-1:0]    tap;
  logic [ACC_W-1:0]    acc;

  // effective settings and decisions for the incoming word
  logic [CMP_W-1:0]    w_eff;
  logic [CMP_W-1:0]    x_ext;
  logic [RADIUS_W-1:0] r_eff;
  logic                last_now;
  logic                x_lt_r;
  logic [RADIUS_W-1:0] k_start;

  always_comb begin
    if (cfg.row_width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(cfg.row_width) > CMP_W'(MAX_ROW_WIDTH)) begin
      w_eff = CMP_W'(MAX_ROW_WIDTH);
    end else begin
      w_eff = CMP_W'(cfg.row_width);
    end
    r_eff    = (cfg.radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : cfg.radius;
    x_ext    = CMP_W'(column_count);
    last_now = (x_ext + CMP_W'(1)) >= w_eff;
    x_lt_r   = x_ext < CMP_W'(r_eff);
    k_start  = x_lt_r ? RADIUS_W'(column_count) : r_eff;
  end

  // tap sample position, clamped to the row start and the newest pixel
  logic signed [4:0]     d_raw;
  logic [WIN_IDX_W-1:0]  d_sel;
  logic [WEIGHT_W-1:0]   tap_weight;
  logic [WEIGHT_W*7-1:0] weights_all;
  logic [PROD_W-1:0]     product;
  logic [ACC_W-1:0]      acc_sum;

  assign weights_all = {cfg.weights_high, cfg.weights_low};

  always_comb begin
    d_raw = $signed({3'b000, k}) + $signed({3'b000, r_q}) - $signed({2'b00, tap});
    if (d_raw[4]) begin
      d_sel = '0;
    end else if (CMP_W'(d_raw[3:0]) > CMP_W'(newest_col)) begin
      d_sel = WIN_IDX_W'(newest_col);
    end else begin
      d_sel = WIN_IDX_W'(d_raw[3:0]);
    end
    tap_weight = weights_all[tap*WEIGHT_W +: WEIGHT_W];
    product    = PROD_W'(tap_weight) * PROD_W'(window[d_sel]);
    acc_sum    = acc + ACC_W'(product);
  end

  assign status.produce  = last_now || !x_lt_r;
  assign status.tap_last = (tap == {r_q, 1'b0});
  assign status.col_last = (k == k_end);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      window[0] <= pixel_in;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
    end else if (cmd.load) begin
      column_count <= last_now ? '0 : column_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      newest_col <= column_count;
      last_q     <= last_now;
      r_q        <= r_eff;
      k          <= k_start;
      k_end      <= last_now ? '0 : k_start;
      tap        <= '0;
      acc        <= '0;
    end else if (cmd.mac) begin
      tap <= tap + TAP_W'(1);
      acc <= acc_sum;
    end else if (cmd.emit) begin
      k   <= k - RADIUS_W'(1);
      tap <= '0;
      acc <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_out  <= (|acc[ACC_W-1:FRAC_BITS+PIXEL_W]) ? '1 :
                    acc[FRAC_BITS+PIXEL_W-1:FRAC_BITS];
      out_column <= COL_W'(newest_col - CNT_W'(k));
      run_last   <= (k == k_end);
      row_end    <= last_q && (k == k_end);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gaussian_row_filter_clamped.sv
// gaussian_row_filter_clamped: top level of the horizontal gaussian row filter
// depends on grfc_pkg, grfc_pixel_if, grfc_result_if, grfc_cfg_if, grfc_cfg_regs,
// grfc_ctrl, grfc_datapath
`default_nettype none

// Horizontal gaussian blur over 8-bit pixels, fed one pixel word per handshake in
// raster order. Each pixel yields the filtered column radius places behind it; the
// first radius pixels of a row yield nothing and the last pixel of a row flushes
// the remaining columns, up to radius+1 result words, the last of them flagged
// run_last and, at the row end, row_end. Samples past either row edge repeat the
// edge pixel. Weights are unsigned Q1.15 (taps 0..3 in weights_low, 4..6 in
// weights_high), the sum is truncated by 15 bits and saturated at 255. Rate: one
// shared 16x8 multiply-accumulate handles one tap per cycle; each result word
// takes its 2*radius+1 taps and then the hand-off into the output register, and
// a pixel takes its accept and then that sequence for each result it causes.
// The output register holds a finished word while the next pixel is accepted; a
// stalled result side holds the sequencer.
// Configuration writes are taken at any time but must only be issued while idle.
module gaussian_row_filter_clamped #(
  parameter int MAX_RADIUS    = grfc_pkg::DEF_MAX_RADIUS,
  parameter int MAX_ROW_WIDTH = grfc_pkg::DEF_MAX_ROW_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  grfc_cfg_if.sink      cfg,
  grfc_pixel_if.sink    pixels,
  grfc_result_if.source results
);
  import grfc_pkg::*;

  cfg_regs_t  regs;
  dp_cmd_t    cmd;
  dp_status_t status;

  // register file, always ready
  grfc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (regs)
  );

  // sequencer: accept a word, run taps, hand each column off
  grfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // window, column count, multiply-accumulate and output register
  grfc_datapath #(
    .MAX_RADIUS    (MAX_RADIUS),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .cmd        (cmd),
    .status     (status),
    .pixel_in   (pixels.pixel_in),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .pixel_out  (results.pixel_out),
    .out_column (results.out_column),
    .row_end    (results.row_end),
    .run_last   (results.run_last)
  );

endmodule

`default_nettype wire
